// ===== rtl/core/dpr_pkg.sv =====
// shared types and constants of the delimited packet receiver
package dpr_pkg;

  // payload buffer size in bytes, one byte is kept for the terminator
  localparam int BUFFER_BYTES = 512;
  localparam int ADDR_W       = $clog2(BUFFER_BYTES);

  // field widths
  localparam int BYTE_W  = 8;
  localparam int MODE_W  = 2;
  localparam int IDX_W   = 9;
  localparam int LEN_W   = 9;
  localparam int PHASE_W = 2;

  // stream and register port widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;

  // command queue between front and back, power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register indexes on the config port
  localparam logic [1:0] REG_START      = 2'd0;
  localparam logic [1:0] REG_END_FIRST  = 2'd1;
  localparam logic [1:0] REG_END_SECOND = 2'd2;

  // register reset values
  localparam logic [BYTE_W-1:0] START_CHAR_RST      = 8'd64;
  localparam logic [BYTE_W-1:0] END_CHAR_FIRST_RST  = 8'd13;
  localparam logic [BYTE_W-1:0] END_CHAR_SECOND_RST = 8'd10;

  typedef enum logic [MODE_W-1:0] {
    MODE_BYTE   = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_READ   = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_e;

  typedef enum logic [PHASE_W-1:0] {
    PH_HUNT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_END     = 2'd2
  } phase_e;

  // classified item handed from front to back
  typedef struct packed {
    mode_e             mode;
    logic              hit_start;
    logic              hit_end_first;
    logic              hit_end_second;
    logic [BYTE_W-1:0] rx_byte;
    logic [ADDR_W-1:0] read_addr;
    logic              read_in_range;
  } cmd_t;

endpackage

// ===== rtl/core/delimited_packet_receiver_top.sv =====
// top level of the delimited packet receiver
// flow: an accepted item is written into the queue, and the back end registers its result
//   once the item reaches the head of the queue and the result output is free
// throughput: one item per cycle while m_axis_tready does not hold back a pending result
// reset: rst_ni clears framing state, write position, ready flag and queue and loads the
//   config reset values; the payload buffer is not cleared and needs no sweep
module delimited_packet_receiver_top
  import dpr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config port, registers at byte address 0, 4 and 8
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready,
  // input items
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // rx_byte [7:0], read_index [16:8]
  input  logic [MODE_W-1:0]      s_axis_tuser,  // mode [1:0]
  // result items
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // packet_ready [0], packet_length [9:1],
                                                // read_data [17:10], frame_state [19:18]
);

  // front to queue
  logic push;
  logic full;
  cmd_t front_cmd;

  // queue to back
  logic q_valid;
  logic pop;
  cmd_t back_cmd;

  // front compares each byte against the delimiter registers up front so the
  // back end only has to pick a transition
  dpr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (front_cmd)
  );

  // two-entry queue lets the input take up to two more items while a result waits
  dpr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (back_cmd)
  );

  // back end owns the framing state and the payload buffer; its state
  // registers double as the result register, so they hold while stalled
  dpr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .cmd_i         (back_cmd),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== rtl/core/dpr_front.sv =====
// front end: config registers, input stream and byte classification
module dpr_front
  import dpr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  input  logic [MODE_W-1:0]     s_axis_tuser,
  input  logic                  full_i,
  output logic                  push_o,
  output cmd_t                  cmd_o
);

  logic [BYTE_W-1:0] start_char_q, end_first_q, end_second_q;
  logic [1:0]        reg_idx;
  logic              cfg_wr;
  logic [BYTE_W-1:0] rx_byte;
  logic [IDX_W-1:0]  read_index;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_char_q <= START_CHAR_RST;
      end_first_q  <= END_CHAR_FIRST_RST;
      end_second_q <= END_CHAR_SECOND_RST;
    end else if (cfg_wr) begin
      priority case (reg_idx)
        REG_START:      start_char_q <= pwdata[BYTE_W-1:0];
        REG_END_FIRST:  end_first_q  <= pwdata[BYTE_W-1:0];
        REG_END_SECOND: end_second_q <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority case (reg_idx)
      REG_START:      prdata = CFG_DATA_W'(start_char_q);
      REG_END_FIRST:  prdata = CFG_DATA_W'(end_first_q);
      REG_END_SECOND: prdata = CFG_DATA_W'(end_second_q);
      default:        prdata = '0;
    endcase
  end

  // tdata: rx_byte [7:0], read_index [16:8]
  assign rx_byte    = s_axis_tdata[BYTE_W-1:0];
  assign read_index = s_axis_tdata[BYTE_W+IDX_W-1:BYTE_W];

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;

  always_comb begin
    cmd_o.mode           = mode_e'(s_axis_tuser);
    cmd_o.hit_start      = (rx_byte == start_char_q);
    cmd_o.hit_end_first  = (rx_byte == end_first_q);
    cmd_o.hit_end_second = (rx_byte == end_second_q);
    cmd_o.rx_byte        = rx_byte;
    cmd_o.read_addr      = ADDR_W'(read_index);
    cmd_o.read_in_range  = (32'(read_index) < 32'(BUFFER_BYTES));
  end

endmodule

// ===== rtl/core/dpr_queue.sv =====
// small command queue between front and back
module dpr_queue
  import dpr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (do_pop && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

// ===== rtl/core/dpr_back.sv =====
// back end: framing state, payload buffer and result register
module dpr_back
  import dpr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  cmd_t                   cmd_i,
  output logic                   pop_o,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  phase_e            phase_q, phase_d;
  logic [ADDR_W-1:0] wpos_q, wpos_d;
  logic              ready_q, ready_d;
  logic              out_valid_q, out_valid_d;
  logic              rd_sel_q, rd_sel_d;
  logic              advance;
  logic              we, re;
  logic [ADDR_W-1:0] waddr;
  logic [BYTE_W-1:0] wdata;
  logic [BYTE_W-1:0] rd_q;
  logic [BYTE_W-1:0] read_data;
  logic [BYTE_W-1:0] mem [BUFFER_BYTES];

  assign advance = q_valid_i && (!out_valid_q || m_axis_tready);
  assign pop_o   = advance;

  always_comb begin
    phase_d     = phase_q;
    wpos_d      = wpos_q;
    ready_d     = ready_q;
    rd_sel_d    = rd_sel_q;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = wpos_q;
    wdata       = cmd_i.rx_byte;
    out_valid_d = out_valid_q && !m_axis_tready;
    if (advance) begin
      out_valid_d = 1'b1;
      rd_sel_d    = 1'b0;
      unique case (cmd_i.mode)
        MODE_BYTE: begin
          unique case (phase_q)
            PH_HUNT: begin
              if (cmd_i.hit_start && !ready_q) begin
                phase_d = PH_PAYLOAD;
                wpos_d  = '0;
              end
            end
            PH_PAYLOAD: begin
              if (cmd_i.hit_end_first) begin
                phase_d = PH_END;
              end else if (wpos_q < ADDR_W'(BUFFER_BYTES - 1)) begin
                we     = 1'b1;
                wpos_d = wpos_q + ADDR_W'(1);
              end
            end
            PH_END: begin
              if (cmd_i.hit_end_second) begin
                phase_d = PH_HUNT;
                we      = 1'b1;
                wdata   = '0;
                ready_d = 1'b1;
              end
            end
            default: phase_d = PH_HUNT;
          endcase
        end
        MODE_CLEAR: ready_d = 1'b0;
        MODE_READ: begin
          re       = cmd_i.read_in_range;
          rd_sel_d = cmd_i.read_in_range;
        end
        MODE_UNUSED: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      wpos_q      <= '0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
      rd_sel_q    <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      wpos_q      <= wpos_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
      rd_sel_q    <= rd_sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[cmd_i.read_addr];
    end
  end

  assign read_data     = rd_sel_q ? rd_q : '0;
  assign m_axis_tvalid = out_valid_q;
  // tdata: packet_ready [0], packet_length [9:1], read_data [17:10], frame_state [19:18]
  assign m_axis_tdata  = {4'b0000, phase_q, read_data, LEN_W'(wpos_q), ready_q};

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> $stable(phase_q) && $stable(wpos_q)
      && $stable(ready_q) && $stable(read_data))
    else $error("result changed while stalled");

  a_wpos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wpos_q <= ADDR_W'(BUFFER_BYTES - 1))
    else $error("write position beyond buffer");

  a_ready_on_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ready_q) |-> $past(phase_q) == PH_END && phase_q == PH_HUNT)
    else $error("ready flag set outside packet close");

  a_pop_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && out_valid_q |-> m_axis_tready)
    else $error("result overwritten before taken");

endmodule
